FILE: hdl/pngu_pkg.sv
// Shared types, constants and helpers for the PNG row unfilter.
package pngu_pkg;

   localparam int PIXEL_BYTES_MAX = 8;
   localparam int HIST_IDX_W      = $clog2(PIXEL_BYTES_MAX);
   localparam int BPP_W           = 4;
   localparam int BYTE_W          = 8;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type_type;

   // history control from the handshake logic
   typedef struct packed {
      logic advance;   // an item is being reconstructed this cycle
      logic clear;     // that item starts a row
   } hist_ctrl_type;

   // bytes-per-pixel to history tap: zero acts as one, large values clamp
   function automatic logic [HIST_IDX_W-1:0] tap_index(input logic [BPP_W-1:0] bpp);
      logic [BPP_W-1:0] span;
      span = bpp;
      if (bpp == '0) begin
         span = BPP_W'(1);
      end else if (bpp > BPP_W'(PIXEL_BYTES_MAX)) begin
         span = BPP_W'(PIXEL_BYTES_MAX);
      end
      return HIST_IDX_W'(span - BPP_W'(1));
   endfunction

endpackage

FILE: hdl/pngu_history.sv
// Left and above byte histories with a selectable tap.
module pngu_history (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pngu_pkg::hist_ctrl_type               ctrl,
   input  logic [pngu_pkg::BYTE_W-1:0]           new_left,
   input  logic [pngu_pkg::BYTE_W-1:0]           new_above,
   input  logic [pngu_pkg::HIST_IDX_W-1:0]       rd_idx,
   output logic [pngu_pkg::BYTE_W-1:0]           left_byte,
   output logic [pngu_pkg::BYTE_W-1:0]           upleft_byte
);

   logic [pngu_pkg::BYTE_W-1:0] left_ff  [pngu_pkg::PIXEL_BYTES_MAX];
   logic [pngu_pkg::BYTE_W-1:0] above_ff [pngu_pkg::PIXEL_BYTES_MAX];
   logic [pngu_pkg::BYTE_W-1:0] left_in  [pngu_pkg::PIXEL_BYTES_MAX];
   logic [pngu_pkg::BYTE_W-1:0] above_in [pngu_pkg::PIXEL_BYTES_MAX];

   // row start reads as an empty history
   assign left_byte   = ctrl.clear ? '0 : left_ff[rd_idx];
   assign upleft_byte = ctrl.clear ? '0 : above_ff[rd_idx];

   always_comb begin
      left_in  = left_ff;
      above_in = above_ff;
      if (ctrl.advance) begin
         for (int k = pngu_pkg::PIXEL_BYTES_MAX - 1; k > 0; k--) begin
            left_in[k]  = ctrl.clear ? '0 : left_ff[k-1];
            above_in[k] = ctrl.clear ? '0 : above_ff[k-1];
         end
         left_in[0]  = new_left;
         above_in[0] = new_above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pngu_pkg::PIXEL_BYTES_MAX; k++) begin
            left_ff[k]  <= '0;
            above_ff[k] <= '0;
         end
      end else begin
         left_ff  <= left_in;
         above_ff <= above_in;
      end
   end

endmodule

FILE: hdl/pngu_predict.sv
// Predictor selection and byte reconstruction.
module pngu_predict (
   input  logic [pngu_pkg::BYTE_W-1:0]  filtered_byte,
   input  logic [pngu_pkg::BYTE_W-1:0]  above_byte,
   input  pngu_pkg::filter_type_type    filter_type,
   input  logic [pngu_pkg::BYTE_W-1:0]  left_byte,
   input  logic [pngu_pkg::BYTE_W-1:0]  upleft_byte,
   output logic [pngu_pkg::BYTE_W-1:0]  recon_byte
);

   logic signed [9:0]           d_bc, d_ac, d_abc;
   logic [8:0]                  pa, pb, pc;
   logic [pngu_pkg::BYTE_W-1:0] paeth;
   logic [pngu_pkg::BYTE_W-1:0] pred;
   logic [8:0]                  avg_sum;

   // p - a = b - c, p - b = a - c, p - c = a + b - 2c
   always_comb begin
      d_bc  = $signed({2'b00, above_byte}) - $signed({2'b00, upleft_byte});
      d_ac  = $signed({2'b00, left_byte})  - $signed({2'b00, upleft_byte});
      d_abc = d_bc + d_ac;
      pa = d_bc[9]  ? 9'(-d_bc)  : 9'(d_bc);
      pb = d_ac[9]  ? 9'(-d_ac)  : 9'(d_ac);
      pc = d_abc[9] ? 9'(-d_abc) : 9'(d_abc);
      if (pa <= pb && pa <= pc) begin
         paeth = left_byte;
      end else if (pb <= pc) begin
         paeth = above_byte;
      end else begin
         paeth = upleft_byte;
      end
   end

   assign avg_sum = {1'b0, left_byte} + {1'b0, above_byte};

   always_comb begin
      case (filter_type)
         pngu_pkg::FILT_NONE:  pred = '0;
         pngu_pkg::FILT_SUB:   pred = left_byte;
         pngu_pkg::FILT_UP:    pred = above_byte;
         pngu_pkg::FILT_AVG:   pred = avg_sum[8:1];
         pngu_pkg::FILT_PAETH: pred = paeth;
         default:              pred = '0;
      endcase
   end

   assign recon_byte = filtered_byte + pred;

endmodule

FILE: hdl/png_row_unfilter.sv
// Top level of the byte-serial PNG scanline reconstruction block.
//
// Usage:
//   req_*  : one filtered byte per word, with the reconstructed byte above it,
//            the row's filter type and a row-start flag (first byte of a row).
//   rsp_*  : one reconstructed byte per accepted request word, in order.
//   csr_*  : bytes-per-pixel (left-neighbor distance), written when idle.
//            0 acts as 1, values above 8 act as 8. Reset value 1.
// Path: an accepted word is held in the input register, then passes through
//   the predictor/add into the result register, from which its byte is taken.
// Throughput: one word per cycle while rsp_tready stays high. The limit is the
//   recurrence through the left-byte history: each result feeds the next byte's
//   predictor when bytes-per-pixel is 1.
// Reset: synchronous, active high. Clears both histories and the valid
//   flags, sets bytes-per-pixel back to 1; req_tready is low while reset is high.
// Stall: while rsp_tready is low the result holds; the input register still
//   takes one more word, then req_tready drops until the result drains.
module png_row_unfilter (
   input  logic        clock,
   input  logic        reset,
   // request: tdata, low bit up = filtered_byte[7:0], above_byte[15:8]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // request: tuser, low bit up = filter_type[2:0], row_start[3]
   input  logic [3:0]  req_tuser,
   // response: tdata = recon_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // bytes_per_pixel register
   input  logic        csr_wen,
   input  logic [3:0]  csr_wdata
);

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic [pngu_pkg::BYTE_W-1:0] in_filt_ff, in_above_ff;
   logic [2:0]                  in_ftype_ff;
   logic                        in_start_ff;

   // result register
   logic                        out_valid_ff, out_valid_in;
   logic [pngu_pkg::BYTE_W-1:0] out_data_ff, out_data_in;

   logic [pngu_pkg::BPP_W-1:0]  bpp_ff, bpp_in;

   logic                        req_take;
   logic                        advance;
   pngu_pkg::hist_ctrl_type     hist_ctrl;
   logic [pngu_pkg::BYTE_W-1:0] left_byte, upleft_byte, recon_byte;

   // the held word moves on when the result slot is free or being emptied
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~reset & (~in_valid_ff | advance);
   assign req_take   = req_tvalid & req_tready;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);
   assign out_data_in  = advance ? recon_byte : out_data_ff;
   assign bpp_in       = csr_wen ? csr_wdata : bpp_ff;

   assign hist_ctrl.advance = advance;
   assign hist_ctrl.clear   = in_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         bpp_ff       <= pngu_pkg::BPP_W'(1);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         bpp_ff       <= bpp_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_filt_ff  <= req_tdata[7:0];
         in_above_ff <= req_tdata[15:8];
         in_ftype_ff <= req_tuser[2:0];
         in_start_ff <= req_tuser[3];
      end
      out_data_ff <= out_data_in;
   end

   pngu_history u_history (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (hist_ctrl),
      .new_left    (recon_byte),
      .new_above   (in_above_ff),
      .rd_idx      (pngu_pkg::tap_index(bpp_ff)),
      .left_byte   (left_byte),
      .upleft_byte (upleft_byte)
   );

   pngu_predict u_predict (
      .filtered_byte (in_filt_ff),
      .above_byte    (in_above_ff),
      .filter_type   (pngu_pkg::filter_type_type'(in_ftype_ff)),
      .left_byte     (left_byte),
      .upleft_byte   (upleft_byte),
      .recon_byte    (recon_byte)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: hdl/pngu_checker.sv
// Port-level checks for the PNG row unfilter, bound to the top level.
module pngu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result holds its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // an empty result slot fills only from an accepted word, by way of the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response appeared without a request");

   // request side never blocks while nothing is held
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && $past(!reset) && !$past(req_tvalid && req_tready) |-> req_tready)
      else $error("req_tready low with empty pipeline");

endmodule

bind png_row_unfilter pngu_checker u_pngu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/tb_png_row_unfilter.sv
// Self-checking testbench for png_row_unfilter: directed table, then random scanlines.
module tb_png_row_unfilter;

   // filter codes outside the PNG set; the block treats them as "none"
   localparam logic [2:0] FILT_RSVD5 = 3'd5;
   localparam logic [2:0] FILT_RSVD6 = 3'd6;
   localparam logic [2:0] FILT_RSVD7 = 3'd7;

   localparam int WORDS_PER_PHASE = 90;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_LIMIT     = 5000;

   // one directed stimulus row; recon is only used when known is set
   typedef struct {
      logic [7:0] filt;
      logic [7:0] above;
      logic [2:0] ftype;
      logic       start;
      bit         known;
      logic [7:0] recon;
   } byte_case_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // filtered_byte, above_byte (low bit up)
   logic [3:0]  req_tuser = '0;   // filter_type, row_start (low bit up)
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // recon_byte
   logic        csr_wen = 1'b0;
   logic [3:0]  csr_wdata = '0;

   // predictor state: [0] is the newest byte
   logic [7:0]  left_hist  [0:pngu_pkg::PIXEL_BYTES_MAX-1];
   logic [7:0]  above_hist [0:pngu_pkg::PIXEL_BYTES_MAX-1];
   logic [3:0]  pixel_bytes = 4'd1;

   logic [7:0]  recon_queue [$];  // reconstructed bytes still owed by the block
   logic [7:0]  want_byte;

   // idling controls shared by sender, receiver and the main sequence
   bit          gaps_on   = 1'b1;
   bit          stalls_on = 1'b1;
   int          hold_cycles = 0;

   int          n_errors  = 0;
   int          n_checked = 0;
   int          n_words   = 0;
   int          n_rows    = 0;
   int          n_configs = 0;

   // Directed part, run at the reset distance of one byte. Typed results are
   // the obvious ones: pass-through, wrap at 255, first pixel of a row seeing
   // zero neighbors, the 9-bit average sum and reserved filter codes acting as none.
   byte_case_type dir_cases [0:17] = '{
      '{8'h00, 8'h00, pngu_pkg::FILT_NONE,  1'b1, 1'b1, 8'h00},
      '{8'hFF, 8'hFF, pngu_pkg::FILT_NONE,  1'b0, 1'b1, 8'hFF},
      '{8'hFF, 8'h00, pngu_pkg::FILT_SUB,   1'b1, 1'b1, 8'hFF},  // left is zero at row start
      '{8'h01, 8'h00, pngu_pkg::FILT_SUB,   1'b0, 1'b1, 8'h00},  // 0x01 + 0xFF wraps
      '{8'h10, 8'hFF, pngu_pkg::FILT_UP,    1'b1, 1'b1, 8'h0F},
      '{8'h80, 8'hFF, pngu_pkg::FILT_AVG,   1'b1, 1'b1, 8'hFF},  // (0 + 255) >> 1
      '{8'h00, 8'hFF, pngu_pkg::FILT_AVG,   1'b0, 1'b1, 8'hFF},  // 9-bit sum, no overflow
      '{8'h00, 8'h40, pngu_pkg::FILT_PAETH, 1'b1, 1'b1, 8'h40},  // a = c = 0, picks above
      '{8'h05, 8'h40, pngu_pkg::FILT_PAETH, 1'b0, 1'b0, 8'h00},  // three-way tie: left
      '{8'h00, 8'h10, pngu_pkg::FILT_PAETH, 1'b0, 1'b0, 8'h00},
      '{8'h33, 8'h77, FILT_RSVD5,           1'b1, 1'b1, 8'h33},
      '{8'h44, 8'h12, FILT_RSVD6,           1'b0, 1'b1, 8'h44},
      '{8'h55, 8'hAB, FILT_RSVD7,           1'b0, 1'b1, 8'h55},
      '{8'h20, 8'h00, pngu_pkg::FILT_SUB,   1'b1, 1'b1, 8'h20},  // restart in mid-stream
      '{8'h01, 8'h00, pngu_pkg::FILT_SUB,   1'b0, 1'b0, 8'h00},
      '{8'h0A, 8'h0F, pngu_pkg::FILT_NONE,  1'b1, 1'b1, 8'h0A},
      '{8'h01, 8'h14, pngu_pkg::FILT_PAETH, 1'b0, 1'b0, 8'h00},  // a=10 b=20 c=15: upper-left
      '{8'hFF, 8'hFF, pngu_pkg::FILT_PAETH, 1'b0, 1'b0, 8'h00}
   };

   png_row_unfilter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      n_errors++;
   endtask

   function automatic int paeth_dist(input int x);
      return (x < 0) ? -x : x;
   endfunction

   // Reconstruct one byte and advance the histories, as the block should.
   function automatic logic [7:0] unfilter_byte(input logic [7:0] filt,
                                                input logic [7:0] above,
                                                input logic [2:0] ftype,
                                                input logic       start);
      int         span;
      int         p, pa, pb, pc;
      logic [7:0] a, c, pred, recon;
      span = (pixel_bytes == 0) ? 1 :
             (pixel_bytes > pngu_pkg::PIXEL_BYTES_MAX) ? pngu_pkg::PIXEL_BYTES_MAX
                                                        : int'(pixel_bytes);
      if (start) begin
         for (int k = 0; k < pngu_pkg::PIXEL_BYTES_MAX; k++) begin
            left_hist[k]  = '0;
            above_hist[k] = '0;
         end
      end
      a = left_hist[span-1];
      c = above_hist[span-1];
      case (ftype)
         pngu_pkg::FILT_SUB:   pred = a;
         pngu_pkg::FILT_UP:    pred = above;
         pngu_pkg::FILT_AVG:   pred = 8'(({1'b0, a} + {1'b0, above}) >> 1);
         pngu_pkg::FILT_PAETH: begin
            p  = int'(a) + int'(above) - int'(c);
            pa = paeth_dist(p - int'(a));
            pb = paeth_dist(p - int'(above));
            pc = paeth_dist(p - int'(c));
            if (pa <= pb && pa <= pc) pred = a;
            else if (pb <= pc)        pred = above;
            else                      pred = c;
         end
         default:              pred = '0;
      endcase
      recon = filt + pred;
      for (int k = pngu_pkg::PIXEL_BYTES_MAX - 1; k > 0; k--) begin
         left_hist[k]  = left_hist[k-1];
         above_hist[k] = above_hist[k-1];
      end
      left_hist[0]  = recon;
      above_hist[0] = above;
      return recon;
   endfunction

   // Offer one word; optional random gap first. Valid only changes on falling
   // edges, and stays high between back-to-back words.
   task automatic send_word(input logic [7:0] filt, input logic [7:0] above,
                            input logic [2:0] ftype, input logic start,
                            input bit known, input logic [7:0] typed_recon);
      logic [7:0] predicted;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {above, filt};
      req_tuser  <= {start, ftype};
      do @(posedge clock); while (!req_tready);
      predicted = unfilter_byte(filt, above, ftype, start);
      recon_queue.push_back(known ? typed_recon : predicted);
      n_words++;
   endtask

   // Register writes only with the pipe empty; this drops valid and waits
   // until every owed byte has come out.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (recon_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Output checker: every accepted byte against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (recon_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected byte 0x%02h", rsp_tdata));
         end else begin
            want_byte = recon_queue.pop_front();
            n_checked++;
            if (rsp_tdata !== want_byte)
               report_mismatch($sformatf("recon_byte 0x%02h, expected 0x%02h",
                                         rsp_tdata, want_byte));
         end
      end
   end

   // Main sequence
   initial begin
      int         plan [0:11];
      logic [7:0] prev_row [0:63];
      logic [7:0] cur_row  [0:63];
      int         prev_len;
      int         len, words, drain;
      bit         noisy;
      logic [2:0] row_ft, ft;
      logic       st;
      logic [7:0] above;

      plan     = '{0, 8, 15, 9, 3, 2, 4, 6, 7, 5, 1, 12};
      prev_len = 0;
      for (int k = 0; k < pngu_pkg::PIXEL_BYTES_MAX; k++) begin
         left_hist[k]  = '0;
         above_hist[k] = '0;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset distance
      foreach (dir_cases[i])
         send_word(dir_cases[i].filt, dir_cases[i].above, dir_cases[i].ftype,
                   dir_cases[i].start, dir_cases[i].known, dir_cases[i].recon);

      // random scanlines, one pixel size per phase; the last phase runs flat out
      foreach (plan[ph]) begin
         wait_idle();
         csr_wen   <= 1'b1;
         csr_wdata <= 4'(plan[ph]);
         @(negedge clock);
         csr_wen   <= 1'b0;
         pixel_bytes = 4'(plan[ph]);
         n_configs++;

         gaps_on   = (ph != $size(plan) - 1);
         stalls_on = gaps_on;
         // back-pressure test: sink holds off while the source keeps offering
         if (ph == 2) begin
            gaps_on     = 1'b0;
            hold_cycles = HOLD_OFF_CYCLES;
         end

         words = 0;
         while (words < WORDS_PER_PHASE) begin
            len    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(4, 40);
            noisy  = ($urandom_range(0, 9) == 0);
            row_ft = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
            for (int i = 0; i < len; i++) begin
               // mostly a real previous row above, otherwise arbitrary bytes
               above = (i < prev_len && $urandom_range(0, 3) != 0) ? prev_row[i]
                                                                 : 8'($urandom);
               if (noisy) begin
                  ft = 3'($urandom);
                  st = (i == 0) ? 1'($urandom) : ($urandom_range(0, 7) == 0);
               end else begin
                  ft = row_ft;
                  st = (i == 0);
               end
               send_word(8'($urandom), above, ft, st, 1'b0, 8'h00);
               cur_row[i] = recon_queue[$];
            end
            prev_row = cur_row;
            prev_len = len;
            n_rows++;
            words += len;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      drain = 0;
      while (recon_queue.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      if (recon_queue.size() != 0)
         report_mismatch($sformatf("%0d bytes never came out", recon_queue.size()));
      repeat (5) @(posedge clock);

      $display("Covered %0d words (%0d random rows) over %0d pixel-size settings, %0d checked.",
               n_words, n_rows, n_configs, n_checked);
      $display("Included filter codes 0-7, row restarts, wrap cases and a %0d-cycle sink hold.",
               HOLD_OFF_CYCLES);
      if (n_errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: png_row_unfilter.f
hdl/pngu_pkg.sv
hdl/pngu_history.sv
hdl/pngu_predict.sv
hdl/png_row_unfilter.sv
hdl/pngu_checker.sv
tb/tb_png_row_unfilter.sv
